@@ rtl/imfd_pkg.sv @@
`default_nettype none
package imfd_pkg;

  localparam int unsigned CountSat = 63;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_SHORT = 2'd1;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

  localparam logic [3:0] KIND_OTHER = 4'd0;
  localparam logic [3:0] KIND_ADD = 4'd1;
  localparam logic [3:0] KIND_EXEC = 4'd2;
  localparam logic [3:0] KIND_EXEC_PRICE = 4'd3;
  localparam logic [3:0] KIND_CANCEL = 4'd4;
  localparam logic [3:0] KIND_DELETE = 4'd5;
  localparam logic [3:0] KIND_REPLACE = 4'd6;
  localparam logic [3:0] KIND_TRADE = 4'd7;
  localparam logic [3:0] KIND_SYSTEM = 4'd8;

  localparam logic [1:0] SIDE_NONE = 2'd0;
  localparam logic [1:0] SIDE_BUY = 2'd1;
  localparam logic [1:0] SIDE_SELL = 2'd2;

  localparam logic [7:0] CHAR_BUY = "B";
  localparam logic [7:0] CHAR_SELL = "S";

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } imfd_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  event_kind;
    logic [15:0] locate_code;
    logic [47:0] time_ns;
    logic [63:0] order_reference;
    logic [63:0] replacement_reference;
    logic [1:0]  trade_side;
    logic [31:0] share_count;
    logic [31:0] price_value;
    logic [63:0] match_id;
    logic [63:0] ticker;
  } imfd_out_t;

  typedef struct packed {
    logic [5:0]  byte_index;
    logic [7:0]  type_code;
    logic [15:0] locate;
    logic [47:0] time_ns;
    logic [63:0] ref_num;
    logic [63:0] new_ref;
    logic [1:0]  side;
    logic [31:0] shares;
    logic [31:0] price;
    logic [63:0] match_num;
    logic [63:0] symbol;
  } imfd_state_t;

  // required message length per type; zero marks an unknown type
  function automatic logic [5:0] needed_len(input logic [7:0] t);
    logic [5:0] n;
    case (t)
      "S": n = 6'd12;
      "R": n = 6'd39;
      "H": n = 6'd25;
      "Y": n = 6'd20;
      "L": n = 6'd26;
      "V": n = 6'd35;
      "W": n = 6'd12;
      "K": n = 6'd28;
      "J": n = 6'd35;
      "h": n = 6'd21;
      "A": n = 6'd36;
      "F": n = 6'd40;
      "E": n = 6'd31;
      "C": n = 6'd36;
      "X": n = 6'd23;
      "D": n = 6'd19;
      "U": n = 6'd35;
      "P": n = 6'd44;
      "Q": n = 6'd40;
      "B": n = 6'd19;
      "I": n = 6'd50;
      "N": n = 6'd20;
      "O": n = 6'd48;
      default: n = 6'd0;
    endcase
    return n;
  endfunction

  function automatic logic [3:0] kind_of(input logic [7:0] t);
    logic [3:0] k;
    case (t)
      "A", "F": k = KIND_ADD;
      "E": k = KIND_EXEC;
      "C": k = KIND_EXEC_PRICE;
      "X": k = KIND_CANCEL;
      "D": k = KIND_DELETE;
      "U": k = KIND_REPLACE;
      "P": k = KIND_TRADE;
      "S": k = KIND_SYSTEM;
      default: k = KIND_OTHER;
    endcase
    return k;
  endfunction

  function automatic logic in_range(input logic [5:0] off, input logic [5:0] lo,
                                    input logic [5:0] n);
    return ({1'b0, off} >= {1'b0, lo}) && ({1'b0, off} < ({1'b0, lo} + {1'b0, n}));
  endfunction

endpackage
`default_nettype wire

@@ rtl/imfd_capture.sv @@
`default_nettype none
module imfd_capture
  import imfd_pkg::*;
(
  input  var imfd_state_t state,
  input  var logic [7:0]  data_byte,
  output imfd_state_t     state_next
);

  logic [5:0] off;
  logic [3:0] k;
  logic       known;

  assign off = state.byte_index;
  assign k = kind_of(state.type_code);
  assign known = needed_len(state.type_code) != 6'd0;

  always_comb begin
    state_next = state;
    state_next.byte_index = (off < 6'(CountSat)) ? off + 6'd1 : 6'(CountSat);
    if (off == 6'd0) begin
      state_next.type_code = data_byte;
    end else if (off < 6'(CountSat) && known) begin
      if (in_range(off, 6'd1, 6'd2))
        state_next.locate = {state.locate[7:0], data_byte};
      if (in_range(off, 6'd5, 6'd6))
        state_next.time_ns = {state.time_ns[39:0], data_byte};
      if (k >= KIND_ADD && k <= KIND_TRADE && in_range(off, 6'd11, 6'd8))
        state_next.ref_num = {state.ref_num[55:0], data_byte};
      case (k)
        KIND_ADD, KIND_TRADE: begin
          if (off == 6'd19)
            state_next.side = (data_byte == CHAR_BUY) ? SIDE_BUY :
                              (data_byte == CHAR_SELL) ? SIDE_SELL : SIDE_NONE;
          if (in_range(off, 6'd20, 6'd4))
            state_next.shares = {state.shares[23:0], data_byte};
          if (in_range(off, 6'd24, 6'd8))
            state_next.symbol = {state.symbol[55:0], data_byte};
          if (in_range(off, 6'd32, 6'd4))
            state_next.price = {state.price[23:0], data_byte};
          if (k == KIND_TRADE && in_range(off, 6'd36, 6'd8))
            state_next.match_num = {state.match_num[55:0], data_byte};
        end
        KIND_EXEC, KIND_EXEC_PRICE, KIND_CANCEL: begin
          if (in_range(off, 6'd19, 6'd4))
            state_next.shares = {state.shares[23:0], data_byte};
          if (k != KIND_CANCEL && in_range(off, 6'd23, 6'd8))
            state_next.match_num = {state.match_num[55:0], data_byte};
          if (k == KIND_EXEC_PRICE && in_range(off, 6'd32, 6'd4))
            state_next.price = {state.price[23:0], data_byte};
        end
        KIND_REPLACE: begin
          if (in_range(off, 6'd19, 6'd8))
            state_next.new_ref = {state.new_ref[55:0], data_byte};
          if (in_range(off, 6'd27, 6'd4))
            state_next.shares = {state.shares[23:0], data_byte};
          if (in_range(off, 6'd31, 6'd4))
            state_next.price = {state.price[23:0], data_byte};
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/itch_message_field_decoder.sv @@
`default_nettype none
// Decodes framed ITCH-style messages presented one byte per request, with
// last_byte set on the final byte. One byte is taken every clock; a byte that
// is not last is accepted even while a decoded event waits in the output
// register, and a last byte is accepted once that register is free or being
// read in the same cycle. The event appears in the cycle after its last byte is
// accepted, loaded into the output register from the one field-capture block.
// On unknown type or short message only status is nonzero.
module itch_message_field_decoder
  import imfd_pkg::*;
(
  input  var logic      clk,
  input  var logic      rst,
  input  var logic      request_valid,
  output logic          request_ready,
  input  var imfd_in_t  request,
  output logic          result_valid,
  input  var logic      result_ready,
  output imfd_out_t     result
);

  imfd_state_t state;
  imfd_state_t state_next;
  imfd_out_t   result_next;
  logic        accept;
  logic [5:0]  need;

  imfd_capture u_capture (
    .state      (state),
    .data_byte  (request.data_byte),
    .state_next (state_next)
  );

  assign request_ready = !result_valid || result_ready || !request.last_byte;
  assign accept = request_valid && request_ready;
  assign need = needed_len(state_next.type_code);

  always_comb begin
    result_next = '0;
    if (need == 6'd0) begin
      result_next.status = STATUS_UNKNOWN;
    end else if (state_next.byte_index < need) begin
      result_next.status = STATUS_SHORT;
    end else begin
      result_next.status = STATUS_OK;
      result_next.event_kind = kind_of(state_next.type_code);
      result_next.locate_code = state_next.locate;
      result_next.time_ns = state_next.time_ns;
      result_next.order_reference = state_next.ref_num;
      result_next.replacement_reference = state_next.new_ref;
      result_next.trade_side = state_next.side;
      result_next.share_count = state_next.shares;
      result_next.price_value = state_next.price;
      result_next.match_id = state_next.match_num;
      result_next.ticker = state_next.symbol;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= request.last_byte ? '0 : state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && request.last_byte) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && request.last_byte) begin
      result <= result_next;
    end
  end

endmodule
`default_nettype wire

@@ tb/tb_itch_message_field_decoder.sv @@
`default_nettype none
module tb_itch_message_field_decoder;
  import imfd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 50000;
  localparam int unsigned MaxIndex = 63;
  localparam int FILL_RANDOM = 0;
  localparam int FILL_ZERO = 1;
  localparam int FILL_ONES = 2;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      request_valid = 1'b0;
  logic      request_ready;
  imfd_in_t  request = '0;
  logic      result_valid;
  logic      result_ready = 1'b0;
  imfd_out_t result;

  itch_message_field_decoder uut (
    .clk(clk),
    .rst(rst),
    .request_valid(request_valid),
    .request_ready(request_ready),
    .request(request),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  always #6 clk = ~clk;

  // decoder shadow state
  int unsigned dec_idx = 0;
  logic [7:0]  dec_type = '0;
  logic [15:0] dec_locate = '0;
  logic [47:0] dec_time = '0;
  logic [63:0] dec_ref = '0;
  logic [63:0] dec_new_ref = '0;
  logic [1:0]  dec_side = '0;
  logic [31:0] dec_shares = '0;
  logic [31:0] dec_price = '0;
  logic [63:0] dec_match = '0;
  logic [63:0] dec_symbol = '0;

  imfd_out_t   pending_events[$];
  imfd_out_t   exp_ev;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned bytes_sent = 0;
  int unsigned msgs_sent = 0;
  int unsigned hold_left = 0;
  bit          idle_tx = 1'b0;
  bit          idle_rx = 1'b0;

  function automatic int unsigned msg_length(input logic [7:0] t);
    case (t)
      "S", "W": return 12;
      "D", "B": return 19;
      "Y", "N": return 20;
      "h": return 21;
      "X": return 23;
      "H": return 25;
      "L": return 26;
      "K": return 28;
      "E": return 31;
      "V", "J", "U": return 35;
      "A", "C": return 36;
      "R": return 39;
      "F", "Q": return 40;
      "P": return 44;
      "O": return 48;
      "I": return 50;
      default: return 0;
    endcase
  endfunction

  function automatic logic [3:0] event_kind_of(input logic [7:0] t);
    case (t)
      "A", "F": return KIND_ADD;
      "E": return KIND_EXEC;
      "C": return KIND_EXEC_PRICE;
      "X": return KIND_CANCEL;
      "D": return KIND_DELETE;
      "U": return KIND_REPLACE;
      "P": return KIND_TRADE;
      "S": return KIND_SYSTEM;
      default: return KIND_OTHER;
    endcase
  endfunction

  function automatic bit in_window(input int unsigned off, input int unsigned lo,
                                   input int unsigned n);
    return off >= lo && off < lo + n;
  endfunction

  function automatic void clear_decoder();
    dec_idx = 0;
    dec_type = '0;
    dec_locate = '0;
    dec_time = '0;
    dec_ref = '0;
    dec_new_ref = '0;
    dec_side = SIDE_NONE;
    dec_shares = '0;
    dec_price = '0;
    dec_match = '0;
    dec_symbol = '0;
  endfunction

  function automatic void capture_byte(input int unsigned off, input logic [7:0] b);
    logic [3:0] k;
    k = event_kind_of(dec_type);
    if (in_window(off, 1, 2)) dec_locate = {dec_locate[7:0], b};
    if (in_window(off, 5, 6)) dec_time = {dec_time[39:0], b};
    if (k >= KIND_ADD && k <= KIND_TRADE && in_window(off, 11, 8))
      dec_ref = {dec_ref[55:0], b};
    case (k)
      KIND_ADD, KIND_TRADE: begin
        if (off == 19)
          dec_side = (b == CHAR_BUY) ? SIDE_BUY : (b == CHAR_SELL) ? SIDE_SELL : SIDE_NONE;
        if (in_window(off, 20, 4)) dec_shares = {dec_shares[23:0], b};
        if (in_window(off, 24, 8)) dec_symbol = {dec_symbol[55:0], b};
        if (in_window(off, 32, 4)) dec_price = {dec_price[23:0], b};
        if (k == KIND_TRADE && in_window(off, 36, 8)) dec_match = {dec_match[55:0], b};
      end
      KIND_EXEC, KIND_EXEC_PRICE, KIND_CANCEL: begin
        if (in_window(off, 19, 4)) dec_shares = {dec_shares[23:0], b};
        if (k != KIND_CANCEL && in_window(off, 23, 8)) dec_match = {dec_match[55:0], b};
        if (k == KIND_EXEC_PRICE && in_window(off, 32, 4)) dec_price = {dec_price[23:0], b};
      end
      KIND_REPLACE: begin
        if (in_window(off, 19, 8)) dec_new_ref = {dec_new_ref[55:0], b};
        if (in_window(off, 27, 4)) dec_shares = {dec_shares[23:0], b};
        if (in_window(off, 31, 4)) dec_price = {dec_price[23:0], b};
      end
      default: ;
    endcase
  endfunction

  function automatic void decode_byte(input imfd_in_t req);
    imfd_out_t   ev;
    int unsigned off;
    int unsigned need;
    off = dec_idx;
    if (off == 0)
      dec_type = req.data_byte;
    else if (off < MaxIndex && msg_length(dec_type) != 0)
      capture_byte(off, req.data_byte);
    dec_idx = (off < MaxIndex) ? off + 1 : MaxIndex;
    if (!req.last_byte) return;
    need = msg_length(dec_type);
    ev = '0;
    if (need == 0) begin
      ev.status = STATUS_UNKNOWN;
    end else if (dec_idx < need) begin
      ev.status = STATUS_SHORT;
    end else begin
      ev.status = STATUS_OK;
      ev.event_kind = event_kind_of(dec_type);
      ev.locate_code = dec_locate;
      ev.time_ns = dec_time;
      ev.order_reference = dec_ref;
      ev.replacement_reference = dec_new_ref;
      ev.trade_side = dec_side;
      ev.share_count = dec_shares;
      ev.price_value = dec_price;
      ev.match_id = dec_match;
      ev.ticker = dec_symbol;
    end
    pending_events.push_back(ev);
    clear_decoder();
  endfunction

  function automatic void cmp_field(input string name, input logic [63:0] e,
                                    input logic [63:0] a);
    if (e !== a) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %h got %h at %0t", name, e, a, $realtime);
    end
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk)
    if (hold_left != 0) hold_left <= hold_left - 1;

  always @(posedge clk)
    if (!rst && request_valid && request_ready) decode_byte(request);

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (pending_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected event at %0t: %p", $realtime, result);
      end else begin
        exp_ev = pending_events.pop_front();
        cmp_field("status", 64'(exp_ev.status), 64'(result.status));
        cmp_field("event_kind", 64'(exp_ev.event_kind), 64'(result.event_kind));
        cmp_field("locate_code", 64'(exp_ev.locate_code), 64'(result.locate_code));
        cmp_field("time_ns", 64'(exp_ev.time_ns), 64'(result.time_ns));
        cmp_field("order_reference", exp_ev.order_reference, result.order_reference);
        cmp_field("replacement_reference", exp_ev.replacement_reference,
                  result.replacement_reference);
        cmp_field("trade_side", 64'(exp_ev.trade_side), 64'(result.trade_side));
        cmp_field("share_count", 64'(exp_ev.share_count), 64'(result.share_count));
        cmp_field("price_value", 64'(exp_ev.price_value), 64'(result.price_value));
        cmp_field("match_id", exp_ev.match_id, result.match_id);
        cmp_field("ticker", exp_ev.ticker, result.ticker);
      end
    end
  end

  // event sink
  initial begin : sink
    int gap;
    while (rst) @(posedge clk);
    forever begin
      gap = idle_rx ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
        result_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      while (hold_left != 0) begin
        result_ready <= 1'b0;
        @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = idle_tx ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      request_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request <= '{data_byte: b, last_byte: last};
    request_valid <= 1'b1;
    do @(posedge clk); while (!request_ready);
  endtask

  task automatic send_msg(input logic [7:0] t, input int unsigned len, input int fill,
                          input logic [7:0] side);
    int unsigned i;
    logic [7:0]  b;
    for (i = 0; i < len; i++) begin
      if (i == 0) b = t;
      else if (i == 19) b = side;
      else if (fill == FILL_ZERO) b = 8'h00;
      else if (fill == FILL_ONES) b = 8'hFF;
      else b = 8'($urandom_range(0, 255));
      send_byte(b, i == len - 1);
    end
    bytes_sent += len;
    msgs_sent++;
  endtask

  function automatic logic [7:0] pick_side();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return CHAR_BUY;
    if (r < 8) return CHAR_SELL;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_unknown_type();
    logic [7:0] t;
    do t = 8'($urandom_range(0, 255)); while (msg_length(t) != 0);
    return t;
  endfunction

  function automatic logic [7:0] pick_known_type();
    logic [7:0] t;
    do t = 8'($urandom_range(0, 255)); while (msg_length(t) == 0);
    return t;
  endfunction

  task automatic test_every_type();
    int unsigned t;
    idle_tx = 1'b0;
    idle_rx = 1'b0;
    for (t = 0; t < 256; t++)
      if (msg_length(8'(t)) != 0)
        send_msg(8'(t), msg_length(8'(t)), FILL_RANDOM, pick_side());
  endtask

  task automatic test_corner_messages();
    idle_tx = 1'b1;
    idle_rx = 1'b1;
    send_msg("A", 36, FILL_ONES, 8'hFF);
    send_msg("P", 44, FILL_RANDOM, 8'h62);
    send_msg(8'h00, 1, FILL_ZERO, 8'h00);
    send_msg(8'hFF, 8, FILL_ONES, 8'hFF);
    send_msg("Z", 5, FILL_RANDOM, 8'h00);
    send_msg("S", 1, FILL_RANDOM, 8'h00);
    send_msg("D", 25, FILL_RANDOM, 8'h00);
    send_msg("I", 66, FILL_RANDOM, 8'h00);
  endtask

  task automatic test_output_stall();
    int n;
    idle_tx = 1'b0;
    idle_rx = 1'b0;
    hold_left <= 400;
    for (n = 0; n < 4; n++) begin
      send_msg("S", 12, FILL_RANDOM, 8'h00);
      if (n % 2 == 0) send_msg(pick_unknown_type(), 1, FILL_RANDOM, 8'h00);
    end
  endtask

  task automatic test_random_stream();
    int          pick;
    logic [7:0]  t;
    int unsigned need;
    int unsigned len;
    int unsigned start_bytes;
    int unsigned start_msgs;
    start_bytes = bytes_sent;
    start_msgs = msgs_sent;
    while (bytes_sent - start_bytes < 80) begin
      if ((msgs_sent - start_msgs) % 8 == 0) begin
        idle_tx = 1'($urandom_range(0, 1));
        idle_rx = 1'($urandom_range(0, 1));
      end
      pick = $urandom_range(0, 99);
      t = pick_known_type();
      need = msg_length(t);
      if (pick < 75) begin
        len = need;
      end else if (pick < 85) begin
        len = need + $urandom_range(1, 6);
      end else if (pick < 93) begin
        len = $urandom_range(1, need - 1);
      end else if (pick < 98) begin
        t = pick_unknown_type();
        len = $urandom_range(1, 40);
      end else begin
        len = $urandom_range(60, 70);
      end
      send_msg(t, len, FILL_RANDOM, pick_side());
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_every_type();
    test_corner_messages();
    test_output_stall();
    test_random_stream();
    request_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire

@@ sim.f @@
rtl/imfd_pkg.sv
rtl/imfd_capture.sv
rtl/itch_message_field_decoder.sv
tb/tb_itch_message_field_decoder.sv
